@@ rtl/core/itcf_pkg.sv @@
package itcf_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AngleFracDef   = 16;
  localparam int SampleBitsDef  = 16;

  localparam int TabQ   = 24;
  localparam int TabLen = 24;

  localparam int GainW  = 16;
  localparam int AlphaW = 17;
  localparam int CfgW   = 17;
  localparam int AngW   = 32;
  localparam int AccAngW = 25;

  localparam logic CFG_GAIN  = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  // Arctangent table, Q24 degrees.
  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = 32'd754974720;
      5'd1:  atan_q24 = 32'd445687602;
      5'd2:  atan_q24 = 32'd235489088;
      5'd3:  atan_q24 = 32'd119537938;
      5'd4:  atan_q24 = 32'd60000934;
      5'd5:  atan_q24 = 32'd30029717;
      5'd6:  atan_q24 = 32'd15018523;
      5'd7:  atan_q24 = 32'd7509720;
      5'd8:  atan_q24 = 32'd3754917;
      5'd9:  atan_q24 = 32'd1877466;
      5'd10: atan_q24 = 32'd938734;
      5'd11: atan_q24 = 32'd469367;
      5'd12: atan_q24 = 32'd234684;
      5'd13: atan_q24 = 32'd117342;
      5'd14: atan_q24 = 32'd58671;
      5'd15: atan_q24 = 32'd29335;
      5'd16: atan_q24 = 32'd14668;
      5'd17: atan_q24 = 32'd7334;
      5'd18: atan_q24 = 32'd3667;
      5'd19: atan_q24 = 32'd1833;
      5'd20: atan_q24 = 32'd917;
      5'd21: atan_q24 = 32'd458;
      5'd22: atan_q24 = 32'd229;
      5'd23: atan_q24 = 32'd115;
      default: atan_q24 = 32'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ rtl/core/itcf_cordic_lane.sv @@
module itcf_cordic_lane #(
  parameter int CORDIC_STEPS    = itcf_pkg::CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = itcf_pkg::AngleFracDef,
  parameter int SAMPLE_BITS     = itcf_pkg::SampleBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] y_in,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic                          done,
  output logic signed [ANGLE_FRAC_BITS+9:0] angle
);
  import itcf_pkg::*;

  localparam int XW   = SAMPLE_BITS + 9;
  localparam int NST  = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
  localparam int CW   = 5;
  localparam int SH   = TabQ - ANGLE_FRAC_BITS;
  localparam int AOW  = ANGLE_FRAC_BITS + 10;

  logic signed [XW-1:0] x, y;
  logic signed [33:0]   z;
  logic [CW-1:0]        step;
  logic                 busy;
  logic                 zero;

  logic signed [XW-1:0] x0, y0, dx, dy;
  logic signed [33:0]   z0, zr;
  logic signed [AOW-1:0] lim;

  always_comb begin
    x0 = XW'(x_in);
    y0 = XW'(y_in);
    z0 = '0;
    if (x_in < 0) begin
      z0 = (y_in >= 0) ? (34'sd180 <<< TabQ) : -(34'sd180 <<< TabQ);
      x0 = -x0;
      y0 = -y0;
    end
    x0 = x0 <<< 6;
    y0 = y0 <<< 6;
    dx = y >>> step;
    dy = x >>> step;
    zr = (z + (34'sd1 <<< (SH - 1))) >>> SH;
    lim = AOW'(180) <<< ANGLE_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= x0; y <= y0; z <= z0;
        zero <= (x_in == 0) && (y_in == 0);
      end else if (busy) begin
        // advance one micro-rotation
        if (y >= 0) begin
          x <= x + dx; y <= y - dy; z <= z + 34'(signed'({1'b0, atan_q24(step)}));
        end else begin
          x <= x - dx; y <= y + dy; z <= z - 34'(signed'({1'b0, atan_q24(step)}));
        end
        step <= step + 1'b1;
        if (32'(step) == NST - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) angle = '0;
    else if (zr > 34'(lim)) angle = lim;
    else if (zr < -34'(lim)) angle = -lim;
    else angle = zr[AOW-1:0];
  end

endmodule

@@ rtl/core/itcf_merge.sv @@
module itcf_merge #(
  parameter int ANGLE_FRAC_BITS = itcf_pkg::AngleFracDef
) (
  input  logic                             clk,
  input  logic                             start,
  input  logic [itcf_pkg::AlphaW-1:0]      alpha,
  input  logic signed [31:0]               prev,
  input  logic signed [33:0]               step,
  input  logic signed [ANGLE_FRAC_BITS+9:0] acc,
  output logic signed [31:0]               fused
);
  import itcf_pkg::*;

  logic [16:0] a;
  logic signed [35:0] gsum;
  logic signed [63:0] p1, p2, v;

  assign a = (alpha > 17'd65536) ? 17'd65536 : alpha;
  assign gsum = 36'(prev) + 36'(step);

  // two products registered, then summed and rounded
  always_ff @(posedge clk) begin
    if (start) begin
      p1 <= 64'(gsum) * 64'(signed'({1'b0, a}));
      p2 <= 64'(acc) * 64'(signed'({1'b0, 17'd65536 - a}));
    end
  end

  assign v = p1 + p2 + 64'sd32768;
  assign fused = sat32(v >>> 16);

endmodule

@@ rtl/core/imu_tilt_complementary_filter.sv @@
// Channel | Signals                                  | Direction
// in      | in_valid, in_stall, acc_*, gyro_*         | sample items arrive
// out     | out_valid, out_stall, *_angle_*           | angle items leave
// cfg     | cfg_we, cfg_index, cfg_data               | register writes
// Each item passes S_RUN, S_MUL, S_FUSE and S_OUT in turn: two CORDIC lanes run
// atan2 side by side, one micro-rotation a cycle, then the blend multiplies.
// Reset is synchronous: clear sums, filter state and registers to defaults.
// An out item waits in the output register while out_stall is high; the next
// item is taken only once that register is free.
module imu_tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = itcf_pkg::CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = itcf_pkg::AngleFracDef,
  parameter int SAMPLE_BITS     = itcf_pkg::SampleBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [itcf_pkg::CfgW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [SAMPLE_BITS-1:0] acc_x,
  input  logic signed [SAMPLE_BITS-1:0] acc_y,
  input  logic signed [SAMPLE_BITS-1:0] acc_z,
  input  logic signed [SAMPLE_BITS-1:0] gyro_x,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] gyro_angle_x,
  output logic signed [31:0] gyro_angle_y,
  output logic signed [31:0] gyro_angle_z,
  output logic signed [24:0] accel_angle_x,
  output logic signed [24:0] accel_angle_y,
  output logic signed [31:0] fused_angle_x,
  output logic signed [31:0] fused_angle_y
);
  import itcf_pkg::*;

  localparam int SH  = TabQ - ANGLE_FRAC_BITS;
  localparam int AOW = ANGLE_FRAC_BITS + 10;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_FUSE = 3'd4;

  logic [2:0] state;
  logic [GainW-1:0]  gain;
  logic [AlphaW-1:0] alpha;
  logic signed [31:0] sum_x, sum_y, sum_z, fus_x, fus_y;
  logic signed [33:0] stp_x, stp_y, stp_z;
  logic signed [SAMPLE_BITS-1:0] gx, gy, gz;
  logic take;
  logic blend_go;
  logic done_x, done_y;
  logic signed [AOW-1:0] ang_x, ang_y, t, ty;
  logic signed [31:0] f_x, f_y;

  assign take = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  // register the blend products once the final angles and steps are held
  assign blend_go = (state == S_MUL);

  // gyro step: raw * gain, rounded half up to the angle fraction
  function automatic logic signed [33:0] gstep(input logic signed [SAMPLE_BITS-1:0] r,
                                               input logic [GainW-1:0] g);
    logic signed [47:0] p;
    p = 48'(r) * 48'(signed'({1'b0, g}));
    gstep = 34'((p + (48'sd1 <<< (SH - 1))) >>> SH);
  endfunction

  always_ff @(posedge clk) begin
    if (take) begin
      gx <= gyro_x; gy <= gyro_y; gz <= gyro_z;
    end
  end

  itcf_cordic_lane #(CORDIC_STEPS, ANGLE_FRAC_BITS, SAMPLE_BITS) u_lane_x (
    .clk, .rst, .start(take), .y_in(acc_y), .x_in(acc_z), .done(done_x), .angle(ang_x));
  itcf_cordic_lane #(CORDIC_STEPS, ANGLE_FRAC_BITS, SAMPLE_BITS) u_lane_y (
    .clk, .rst, .start(take), .y_in(acc_z), .x_in(acc_x), .done(done_y), .angle(ang_y));

  // mounting offset for Y tilt
  always_comb begin
    t = ang_y + (AOW'(180) <<< ANGLE_FRAC_BITS);
    if (t > (AOW'(90) <<< ANGLE_FRAC_BITS)) ty = t - (AOW'(270) <<< ANGLE_FRAC_BITS);
    else ty = t + (AOW'(90) <<< ANGLE_FRAC_BITS);
  end

  itcf_merge #(ANGLE_FRAC_BITS) u_merge_x (
    .clk, .start(blend_go), .alpha, .prev(fus_x), .step(stp_x), .acc(ang_x), .fused(f_x));
  itcf_merge #(ANGLE_FRAC_BITS) u_merge_y (
    .clk, .start(blend_go), .alpha, .prev(fus_y), .step(stp_y), .acc(ty), .fused(f_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gain <= GainW'(23488);
      alpha <= AlphaW'(63570);
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      fus_x <= '0; fus_y <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:  gain <= cfg_data[GainW-1:0];
          CFG_ALPHA: alpha <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (take) state <= S_RUN;
        S_RUN: begin
          if (done_x && done_y) begin
            // hold the gyro steps; the running sums update in S_MUL
            stp_x <= gstep(gx, gain);
            stp_y <= gstep(gy, gain);
            stp_z <= gstep(gz, gain);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sum_x <= sat32(64'(sum_x) + 64'(stp_x));
          sum_y <= sat32(64'(sum_y) + 64'(stp_y));
          sum_z <= sat32(64'(sum_z) + 64'(stp_z));
          accel_angle_x <= ang_x[24:0];
          accel_angle_y <= ty[24:0];
          state <= S_FUSE;
        end
        S_FUSE: begin
          // take the rounded blend from the registered products
          fus_x <= f_x;
          fus_y <= f_y;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign gyro_angle_x = sum_x;
  assign gyro_angle_y = sum_y;
  assign gyro_angle_z = sum_z;
  assign fused_angle_x = fus_x;
  assign fused_angle_y = fus_y;

endmodule
